// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `ASSERT_ALWAYS(lbl, (ante) |-> (cons), msg)

`endif

// ===== sv/wlvs_pkg.sv =====
package wlvs_pkg;

  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned INDEX_WIDTH  = 48;
  localparam int unsigned TIME_WIDTH   = 64;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 2'd0,
    CFG_HIGH_LIMIT = 2'd1,
    CFG_ROW_OFFSET = 2'd2
  } cfg_index_e;

  localparam logic REC_SEGMENT = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef enum logic {
    PH_SEGMENT,
    PH_SUMMARY
  } back_phase_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/wlvs_front.sv =====
module wlvs_front #(
  parameter int unsigned S = 32,
  parameter int unsigned I = 48,
  parameter int unsigned T = 64,
  parameter int unsigned CFG_W = (S > I) ? S : I,
  parameter int unsigned JOB_W = 2 + 4 * I + 2 * T + 4 * S
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wlvs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [S-1:0]                   sample_value_i,
  input  logic [T-1:0]                   sample_time_i,
  input  logic                           sample_invalid_i,
  input  logic                           last_sample_i,
  input  wlvs_pkg::q_status_t            q_stat_i,
  output logic                           push_o,
  output logic [JOB_W-1:0]               job_o
);
  import wlvs_pkg::*;

  typedef struct packed {
    logic         seg_valid;
    logic         sum_valid;
    logic [I-1:0] first_index;
    logic [I-1:0] final_index;
    logic [T-1:0] first_time;
    logic [T-1:0] final_time;
    logic [S-1:0] seg_min;
    logic [S-1:0] seg_max;
    logic [S-1:0] sum_min;
    logic [S-1:0] sum_max;
    logic [I-1:0] point_total;
    logic [I-1:0] violation_total;
  } job_t;

  logic [S-1:0] low_q, high_q;
  logic [I-1:0] offset_q;

  logic         in_run_q, in_run_d;
  logic [I-1:0] row_q, row_d, vc_q, vc_d;
  logic [I-1:0] rs_idx_q, rs_idx_d, re_idx_q, re_idx_d;
  logic [T-1:0] rs_time_q, rs_time_d, re_time_q, re_time_d;
  logic [S-1:0] rmin_q, rmin_d, rmax_q, rmax_d;
  logic [S-1:0] omin_q, omin_d, omax_q, omax_d;

  logic [I-1:0] idx;
  logic         viol, accept, emit_seg, any;
  job_t         job;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    idx  = offset_q + row_q;
    viol = !sample_invalid_i &&
           (($signed(sample_value_i) < $signed(low_q)) ||
            ($signed(high_q) < $signed(sample_value_i)));

    row_d     = (row_q == '1) ? row_q : row_q + I'(1);
    vc_d      = vc_q;
    omin_d    = omin_q;
    omax_d    = omax_q;
    rs_idx_d  = rs_idx_q;
    re_idx_d  = re_idx_q;
    rs_time_d = rs_time_q;
    re_time_d = re_time_q;
    rmin_d    = rmin_q;
    rmax_d    = rmax_q;

    if (viol) begin
      if (vc_q == '0) begin
        omin_d = sample_value_i;
        omax_d = sample_value_i;
      end else begin
        if ($signed(sample_value_i) < $signed(omin_q)) omin_d = sample_value_i;
        if ($signed(omax_q) < $signed(sample_value_i)) omax_d = sample_value_i;
      end
      vc_d = (vc_q == '1) ? vc_q : vc_q + I'(1);
      if (in_run_q) begin
        re_idx_d  = idx;
        re_time_d = sample_time_i;
        if ($signed(sample_value_i) < $signed(rmin_q)) rmin_d = sample_value_i;
        if ($signed(rmax_q) < $signed(sample_value_i)) rmax_d = sample_value_i;
      end else begin
        rs_idx_d  = idx;
        re_idx_d  = idx;
        rs_time_d = sample_time_i;
        re_time_d = sample_time_i;
        rmin_d    = sample_value_i;
        rmax_d    = sample_value_i;
      end
    end

    // a run closes on the first non-violating beat (in range or invalid) or at end of stream
    emit_seg = (in_run_q || viol) && (!viol || last_sample_i);
    in_run_d = (in_run_q || viol) && !emit_seg;
    any      = vc_d != '0;

    job.seg_valid       = emit_seg;
    job.sum_valid       = last_sample_i;
    job.first_index     = rs_idx_d;
    job.final_index     = re_idx_d;
    job.first_time      = rs_time_d;
    job.final_time      = re_time_d;
    job.seg_min         = rmin_d;
    job.seg_max         = rmax_d;
    job.sum_min         = any ? omin_d : '0;
    job.sum_max         = any ? omax_d : '0;
    job.point_total     = row_d;
    job.violation_total = vc_d;
  end

  assign push_o = accept && (emit_seg || last_sample_i);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= {1'b1, {(S - 1){1'b0}}};
      high_q   <= {1'b0, {(S - 1){1'b1}}};
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOW_LIMIT:  low_q    <= cfg_data_i[S-1:0];
        CFG_HIGH_LIMIT: high_q   <= cfg_data_i[S-1:0];
        CFG_ROW_OFFSET: offset_q <= cfg_data_i[I-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q <= 1'b0;
      row_q    <= '0;
      vc_q     <= '0;
    end else if (accept) begin
      if (last_sample_i) begin
        in_run_q <= 1'b0;
        row_q    <= '0;
        vc_q     <= '0;
      end else begin
        in_run_q <= in_run_d;
        row_q    <= row_d;
        vc_q     <= vc_d;
      end
    end
  end

  // only read once the run or the violation count says they are set
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rs_idx_q  <= rs_idx_d;
      re_idx_q  <= re_idx_d;
      rs_time_q <= rs_time_d;
      re_time_q <= re_time_d;
      rmin_q    <= rmin_d;
      rmax_q    <= rmax_d;
      omin_q    <= omin_d;
      omax_q    <= omax_d;
    end
  end

endmodule

// ===== sv/wlvs_queue.sv =====
`include "assert_macros.svh"

module wlvs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    rdata_o,
  output wlvs_pkg::q_status_t stat_o
);
  import wlvs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign stat_o.full  = cnt_q == CW'(DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign rdata_o      = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push_i && stat_o.full), "push into full queue")
  `ASSERT_ALWAYS(a_no_underflow, !(pop_i && stat_o.empty), "pop from empty queue")

endmodule

// ===== sv/wlvs_back.sv =====
`include "assert_macros.svh"

module wlvs_back #(
  parameter int unsigned S = 32,
  parameter int unsigned I = 48,
  parameter int unsigned T = 64,
  parameter int unsigned JOB_W = 2 + 4 * I + 2 * T + 4 * S,
  parameter int unsigned OUT_W = ((4 * I + 2 * T + 2 * S + 1 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  logic [JOB_W-1:0] head_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);
  import wlvs_pkg::*;

  typedef struct packed {
    logic         seg_valid;
    logic         sum_valid;
    logic [I-1:0] first_index;
    logic [I-1:0] final_index;
    logic [T-1:0] first_time;
    logic [T-1:0] final_time;
    logic [S-1:0] seg_min;
    logic [S-1:0] seg_max;
    logic [S-1:0] sum_min;
    logic [S-1:0] sum_max;
    logic [I-1:0] point_total;
    logic [I-1:0] violation_total;
  } job_t;

  job_t        head;
  back_phase_e phase_q, phase_d;
  logic        load, sel_sum, out_vld_q;

  logic         kind_q, last_q, any_q;
  logic [I-1:0] fi_q, li_q, pt_q, vt_q;
  logic [T-1:0] ft_q, lt_q;
  logic [S-1:0] lo_q, hi_q;

  assign head = job_t'(head_i);
  assign load = head_valid_i && (!out_vld_q || m_axis_tready);

  always_comb begin
    phase_d = phase_q;
    sel_sum = (phase_q == PH_SUMMARY) || !head.seg_valid;
    unique case (phase_q)
      PH_SEGMENT: if (load && head.seg_valid && head.sum_valid) phase_d = PH_SUMMARY;
      PH_SUMMARY: if (load) phase_d = PH_SEGMENT;
      default:    phase_d = PH_SEGMENT;
    endcase
    pop_o = load && (sel_sum || !head.sum_valid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEGMENT;
      out_vld_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load)               out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= sel_sum ? REC_SUMMARY : REC_SEGMENT;
      fi_q   <= sel_sum ? '0 : head.first_index;
      li_q   <= sel_sum ? '0 : head.final_index;
      ft_q   <= sel_sum ? '0 : head.first_time;
      lt_q   <= sel_sum ? '0 : head.final_time;
      lo_q   <= sel_sum ? head.sum_min : head.seg_min;
      hi_q   <= sel_sum ? head.sum_max : head.seg_max;
      pt_q   <= head.point_total;
      vt_q   <= head.violation_total;
      any_q  <= head.violation_total != '0;
      last_q <= sel_sum || !head.sum_valid;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = OUT_W'({any_q, vt_q, pt_q, hi_q, lo_q, lt_q, ft_q, li_q, fi_q});

  `ASSERT_IMPLIES(a_phase_head, phase_q == PH_SUMMARY, head_valid_i && head.sum_valid, "summary pending without queued job")
  `ASSERT_IMPLIES(a_phase_out, phase_q == PH_SUMMARY, out_vld_q && kind_q == REC_SEGMENT && !last_q, "segment beat not ahead of summary")
  `ASSERT_IMPLIES(a_sum_last, out_vld_q && kind_q == REC_SUMMARY, last_q, "summary beat without tlast")

endmodule

// ===== sv/window_limit_violation_segmenter.sv =====
// Path: an accepted beat is written into the job queue, then loaded into the output register.
// Throughput: one input beat per cycle while the job queue is not full; a beat that
// closes a segment and ends the stream gives two output beats, segment then summary.
// A 4-entry job queue decouples the compare/run stage from the record output.
// Reset: run and counters cleared, limits open to the full signed range,
// row offset 0; end of stream clears run and counters again.
module window_limit_violation_segmenter #(
  parameter int unsigned SAMPLE_WIDTH = wlvs_pkg::SAMPLE_WIDTH,
  parameter int unsigned INDEX_WIDTH  = wlvs_pkg::INDEX_WIDTH,
  parameter int unsigned TIME_WIDTH   = wlvs_pkg::TIME_WIDTH,
  parameter int unsigned QUEUE_DEPTH  = wlvs_pkg::QUEUE_DEPTH,
  parameter int unsigned CFG_W  = (SAMPLE_WIDTH > INDEX_WIDTH) ? SAMPLE_WIDTH : INDEX_WIDTH,
  parameter int unsigned IN_W   = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8,
  parameter int unsigned OUT_W  =
    ((4 * INDEX_WIDTH + 2 * TIME_WIDTH + 2 * SAMPLE_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wlvs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample_value, sample_time
  input  logic [IN_W-1:0]                s_axis_tdata,
  // sample_invalid
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // first_index, final_index, first_time, final_time, low_value, high_value,
  // point_total, violation_total, any_violation
  output logic [OUT_W-1:0]               m_axis_tdata,
  // record_kind
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import wlvs_pkg::*;

  localparam int unsigned JOB_W = 2 + 4 * INDEX_WIDTH + 2 * TIME_WIDTH + 4 * SAMPLE_WIDTH;

  logic [JOB_W-1:0] push_job, head_job;
  logic             push, pop;
  q_status_t        q_stat;

  wlvs_front #(
    .S(SAMPLE_WIDTH), .I(INDEX_WIDTH), .T(TIME_WIDTH), .CFG_W(CFG_W), .JOB_W(JOB_W)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .sample_value_i   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .sample_time_i    (s_axis_tdata[SAMPLE_WIDTH+TIME_WIDTH-1:SAMPLE_WIDTH]),
    .sample_invalid_i (s_axis_tuser),
    .last_sample_i    (s_axis_tlast),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .job_o            (push_job)
  );

  wlvs_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .stat_o  (q_stat)
  );

  wlvs_back #(
    .S(SAMPLE_WIDTH), .I(INDEX_WIDTH), .T(TIME_WIDTH), .JOB_W(JOB_W), .OUT_W(OUT_W)
  ) u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (!q_stat.empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import wlvs_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned IW    = INDEX_WIDTH;
  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned CFG_W = (SW > IW) ? SW : IW;
  localparam int unsigned IN_W  = ((SW + TW + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((4 * IW + 2 * TW + 2 * SW + 1 + 7) / 8) * 8;

  // bit offsets of the record fields in m_axis_tdata
  localparam int unsigned OFS_FI  = 0;
  localparam int unsigned OFS_LI  = OFS_FI + IW;
  localparam int unsigned OFS_FT  = OFS_LI + IW;
  localparam int unsigned OFS_LT  = OFS_FT + TW;
  localparam int unsigned OFS_LO  = OFS_LT + TW;
  localparam int unsigned OFS_HI  = OFS_LO + SW;
  localparam int unsigned OFS_PT  = OFS_HI + SW;
  localparam int unsigned OFS_VT  = OFS_PT + IW;
  localparam int unsigned OFS_ANY = OFS_VT + IW;

  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [IW-1:0] IDX_MAX = '1;

  // output register plus a 4-entry job queue
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned IDLE_GUARD   = 60000;
  localparam int unsigned TIMEOUT_UNITS = 6000000;
  localparam int unsigned MAX_PRINTS   = 30;

  typedef struct {
    logic signed [SW-1:0] value;
    logic [TW-1:0]        stamp;
    logic                 invalid;
    logic                 last;
    int unsigned          gap;
    bit                   hold;
  } sample_t;

  typedef struct {
    logic                 kind;
    logic [IW-1:0]        first_index;
    logic [IW-1:0]        final_index;
    logic [TW-1:0]        first_stamp;
    logic [TW-1:0]        end_stamp;
    logic signed [SW-1:0] low_value;
    logic signed [SW-1:0] high_value;
    logic [IW-1:0]        point_total;
    logic [IW-1:0]        violation_total;
    logic                 any_violation;
    logic                 last_record;
  } record_t;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]   cfg_data_i  = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;   // sample_value, sample_time
  logic               s_axis_tuser = 1'b0; // sample_invalid
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;        // first_index .. any_violation
  logic               m_axis_tuser;        // record_kind
  logic               m_axis_tlast;

  window_limit_violation_segmenter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // limit window and row base as currently programmed
  logic signed [SW-1:0] lim_low  = SMIN;
  logic signed [SW-1:0] lim_high = SMAX;
  logic [IW-1:0]        row_base = '0;

  // segmenter state
  logic                 run_open = 1'b0;
  logic [IW-1:0]        seg_first_idx = '0;
  logic [IW-1:0]        seg_last_idx  = '0;
  logic [TW-1:0]        seg_first_stamp = '0;
  logic [TW-1:0]        seg_last_stamp  = '0;
  logic signed [SW-1:0] seg_min = '0;
  logic signed [SW-1:0] seg_max = '0;
  logic [IW-1:0]        rows_seen  = '0;
  logic [IW-1:0]        viols_seen = '0;
  logic signed [SW-1:0] viol_min = '0;
  logic signed [SW-1:0] viol_max = '0;

  sample_t     pending_samples[$];
  record_t     expected_records[$];
  sample_t     cur_sample;
  bit          beat_pending = 1'b0;
  int unsigned wait_left = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned n_samples = 0;
  int unsigned n_records = 0;
  int unsigned n_segments = 0;
  int unsigned n_summaries = 0;
  int unsigned n_settings = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic logic [IW-1:0] bump(input logic [IW-1:0] c);
    return (&c) ? c : c + IW'(1);
  endfunction

  task automatic clear_stream();
    run_open = 1'b0;
    seg_first_idx = '0;
    seg_last_idx = '0;
    seg_first_stamp = '0;
    seg_last_stamp = '0;
    seg_min = '0;
    seg_max = '0;
    rows_seen = '0;
    viols_seen = '0;
    viol_min = '0;
    viol_max = '0;
  endtask

  task automatic predict_records(input sample_t s);
    logic [IW-1:0] idx;
    logic          viol;
    record_t       r;
    idx  = row_base + rows_seen;
    viol = !s.invalid && (s.value < lim_low || s.value > lim_high);
    rows_seen = bump(rows_seen);
    if (viol) begin
      if (viols_seen == '0) begin
        viol_min = s.value;
        viol_max = s.value;
      end else begin
        if (s.value < viol_min) viol_min = s.value;
        if (s.value > viol_max) viol_max = s.value;
      end
      viols_seen = bump(viols_seen);
      if (run_open) begin
        seg_last_idx = idx;
        seg_last_stamp = s.stamp;
        if (s.value < seg_min) seg_min = s.value;
        if (s.value > seg_max) seg_max = s.value;
      end else begin
        run_open = 1'b1;
        seg_first_idx = idx;
        seg_last_idx = idx;
        seg_first_stamp = s.stamp;
        seg_last_stamp = s.stamp;
        seg_min = s.value;
        seg_max = s.value;
      end
    end
    r.point_total     = rows_seen;
    r.violation_total = viols_seen;
    r.any_violation   = (viols_seen != '0);
    if (run_open && (!viol || s.last)) begin
      r.kind        = REC_SEGMENT;
      r.first_index = seg_first_idx;
      r.final_index = seg_last_idx;
      r.first_stamp = seg_first_stamp;
      r.end_stamp   = seg_last_stamp;
      r.low_value   = seg_min;
      r.high_value  = seg_max;
      r.last_record = !s.last;   // summary follows on end of stream
      expected_records.insert(expected_records.size(), r);
      run_open = 1'b0;
    end
    if (s.last) begin
      r.kind        = REC_SUMMARY;
      r.first_index = '0;
      r.final_index = '0;
      r.first_stamp = '0;
      r.end_stamp   = '0;
      r.low_value   = r.any_violation ? viol_min : '0;
      r.high_value  = r.any_violation ? viol_max : '0;
      r.last_record = 1'b1;
      expected_records.insert(expected_records.size(), r);
      clear_stream();
    end
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      beat_pending = 1'b0;
      wait_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_records(cur_sample);
        n_samples++;
        beat_pending = 1'b0;
      end
      if (!beat_pending && pending_samples.size() != 0) begin
        cur_sample = pending_samples.pop_front();
        beat_pending = 1'b1;
        wait_left = cur_sample.gap;
      end
      if (!beat_pending) begin
        s_axis_tvalid <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cur_sample.hold && expected_records.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_sample.hold = 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({cur_sample.stamp, cur_sample.value});
        s_axis_tuser  <= cur_sample.invalid;
        s_axis_tlast  <= cur_sample.last;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d: %s is %h, expected %h",
                                n_records, name, got, want));
  endtask

  task automatic check_record();
    record_t seen;
    record_t want;
    seen.kind            = m_axis_tuser;
    seen.first_index     = m_axis_tdata[OFS_FI +: IW];
    seen.final_index     = m_axis_tdata[OFS_LI +: IW];
    seen.first_stamp     = m_axis_tdata[OFS_FT +: TW];
    seen.end_stamp       = m_axis_tdata[OFS_LT +: TW];
    seen.low_value       = m_axis_tdata[OFS_LO +: SW];
    seen.high_value      = m_axis_tdata[OFS_HI +: SW];
    seen.point_total     = m_axis_tdata[OFS_PT +: IW];
    seen.violation_total = m_axis_tdata[OFS_VT +: IW];
    seen.any_violation   = m_axis_tdata[OFS_ANY];
    seen.last_record     = m_axis_tlast;
    n_records++;
    if (expected_records.size() == 0) begin
      report_mismatch($sformatf("record %0d arrived with none expected", n_records));
      return;
    end
    want = expected_records.pop_front();
    if (want.kind == REC_SUMMARY) n_summaries++;
    else n_segments++;
    check_field("record_kind", seen.kind, want.kind);
    check_field("first_index", seen.first_index, want.first_index);
    check_field("final_index", seen.final_index, want.final_index);
    check_field("first_time", seen.first_stamp, want.first_stamp);
    check_field("final_time", seen.end_stamp, want.end_stamp);
    check_field("low_value", seen.low_value, want.low_value);
    check_field("high_value", seen.high_value, want.high_value);
    check_field("point_total", seen.point_total, want.point_total);
    check_field("violation_total", seen.violation_total, want.violation_total);
    check_field("any_violation", seen.any_violation, want.any_violation);
    check_field("last_record", seen.last_record, want.last_record);
  endtask

  // record monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_record();
        stall_left = calm ? 0 : $urandom_range(0, 15);
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int unsigned sender_gap();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic queue_sample(input logic signed [SW-1:0] v, input logic [TW-1:0] t,
                              input logic inv, input logic lst, input bit hold);
    sample_t s;
    s.value   = v;
    s.stamp   = t;
    s.invalid = inv;
    s.last    = lst;
    s.gap     = sender_gap();
    s.hold    = hold;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LOW_LIMIT:  lim_low  = value[SW-1:0];
      CFG_HIGH_LIMIT: lim_high = value[SW-1:0];
      CFG_ROW_OFFSET: row_base = value[IW-1:0];
      default: ;
    endcase
  endtask

  // limits go out with junk in the unused upper bits
  task automatic configure(input logic signed [SW-1:0] lo, input logic signed [SW-1:0] hi,
                           input logic [IW-1:0] off);
    logic [CFG_W-1:0] d;
    d = CFG_W'({$urandom(), $urandom()});
    d[SW-1:0] = lo;
    write_reg(CFG_LOW_LIMIT, d);
    d = CFG_W'({$urandom(), $urandom()});
    d[SW-1:0] = hi;
    write_reg(CFG_HIGH_LIMIT, d);
    write_reg(CFG_ROW_OFFSET, CFG_W'(off));
    n_settings++;
  endtask

  // all beats taken and all records back, then let the pipeline empty
  task automatic settle();
    int unsigned guard;
    guard = 0;
    while ((pending_samples.size() != 0 || beat_pending || expected_records.size() != 0)
           && guard < IDLE_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_records.size() != 0) begin
      report_mismatch($sformatf("%0d records never arrived", expected_records.size()));
      expected_records.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // value inside or outside the current window, edges favoured
  function automatic logic signed [SW-1:0] pick_value(input bit want_viol);
    longint lo, hi, a, b, smin, smax;
    longint unsigned span;
    smin = SMIN;
    smax = SMAX;
    lo = lim_low;
    hi = lim_high;
    a = smin;
    b = smax;
    if (lo <= hi) begin
      if (!want_viol) begin
        a = lo;
        b = hi;
      end else if (lo > smin && (hi == smax || $urandom_range(0, 1) == 0)) begin
        a = smin;
        b = lo - 1;
      end else if (hi < smax) begin
        a = hi + 1;
        b = smax;
      end
    end
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 0) ? SW'(a) : SW'(b);
    span = b - a + 1;
    return SW'(a + longint'({$urandom(), $urandom()} % span));
  endfunction

  // runs of violations and in-range stretches, with invalid samples and
  // early stream ends mixed in; the phase always closes its stream
  task automatic random_phase(input int unsigned count);
    bit            viol_run;
    logic [TW-1:0] stamp;
    logic          lst;
    viol_run = 1'b0;
    stamp = TW'({$urandom(), $urandom()}) >> $urandom_range(0, 63);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) viol_run = !viol_run;
      if ($urandom_range(0, 49) == 0) stamp = TW'({$urandom(), $urandom()});
      else stamp = stamp + $urandom_range(1, 1000);
      lst = (i == count - 1) || ($urandom_range(0, 39) == 0);
      queue_sample(pick_value(viol_run), stamp, $urandom_range(0, 9) == 0, lst,
                   $urandom_range(0, 39) == 0);
    end
  endtask

  initial begin : stimulus
    logic signed [SW-1:0] lo_v, hi_v, ra, rb;
    logic [IW-1:0]        off_v;
    int unsigned          cnt;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: nothing can violate, summary only
    queue_sample(SMIN, '0, 1'b0, 1'b0, 1'b0);
    queue_sample(SMAX, '1, 1'b1, 1'b0, 1'b0);
    queue_sample('0, 64'h5a5a_0f0f_c3c3_9696, 1'b0, 1'b1, 1'b0);
    settle();

    // row index wraps inside the first run
    configure(-32'sd1000, 32'sd1000, IDX_MAX - IW'(1));
    queue_sample(32'sd5, 64'd10, 1'b0, 1'b0, 1'b0);
    queue_sample(-32'sd1001, 64'd11, 1'b0, 1'b0, 1'b0);
    queue_sample(32'sd2000, 64'd12, 1'b0, 1'b0, 1'b0);
    queue_sample(SMIN, '1, 1'b0, 1'b0, 1'b0);
    queue_sample(SMAX, 64'd14, 1'b0, 1'b0, 1'b0);
    queue_sample(SMIN, 64'd15, 1'b1, 1'b0, 1'b0);
    queue_sample(32'sd1000, 64'd16, 1'b0, 1'b0, 1'b0);
    queue_sample(-32'sd1000, 64'd17, 1'b0, 1'b0, 1'b0);
    queue_sample(32'sd1001, 64'd18, 1'b0, 1'b0, 1'b0);
    queue_sample(SMAX, 64'd19, 1'b1, 1'b1, 1'b0);
    queue_sample(-32'sd1001, '0, 1'b0, 1'b1, 1'b1);
    settle();

    // crossed limits: every valid sample violates
    configure(32'sd10, -32'sd10, IDX_MAX);
    queue_sample('0, 64'd100, 1'b0, 1'b0, 1'b0);
    queue_sample(-32'sd5, 64'd101, 1'b0, 1'b0, 1'b0);
    queue_sample(SMAX, 64'd102, 1'b1, 1'b0, 1'b0);
    queue_sample(32'sd20, 64'd103, 1'b0, 1'b1, 1'b0);
    settle();

    // window of a single value, stream ends on an in-range sample
    configure(32'sh1234, 32'sh1234, '0);
    queue_sample(32'sh1234, 64'd7, 1'b0, 1'b0, 1'b0);
    queue_sample(32'sh1235, 64'd8, 1'b0, 1'b0, 1'b0);
    queue_sample(32'sh1233, 64'd9, 1'b0, 1'b0, 1'b0);
    queue_sample(32'sh1234, 64'd10, 1'b0, 1'b1, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      ra = $urandom();
      rb = $urandom();
      off_v = IW'({$urandom(), $urandom()});
      calm = 1'b0;
      cnt = 190;
      case (p)
        0: begin lo_v = SMIN; hi_v = $urandom_range(0, 1 << 20); off_v = '0; end
        1: begin lo_v = 0 - $urandom_range(0, 1 << 20); hi_v = SMAX; off_v = IDX_MAX; calm = 1'b1; end
        2: begin lo_v = ra; hi_v = ra; end
        3: begin lo_v = SMAX; hi_v = SMIN; off_v = IDX_MAX - 5; end
        4: begin lo_v = SMIN; hi_v = SMAX; calm = 1'b1; cnt = 70; end
        5: begin lo_v = (ra > rb) ? ra : rb; hi_v = (ra > rb) ? rb : ra; end
        6: begin lo_v = 0 - $urandom_range(0, 1 << 16); hi_v = $urandom_range(0, 1 << 16); off_v = '0; end
        default: begin lo_v = (ra > rb) ? rb : ra; hi_v = (ra > rb) ? ra : rb; end
      endcase
      configure(lo_v, hi_v, off_v);
      random_phase(cnt);
      settle();
    end

    $display("Sent %0d samples under %0d limit settings; checked %0d records", n_samples,
             n_settings + 1, n_records);
    $display("(%0d segments, %0d summaries), %0d mismatches", n_segments, n_summaries,
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_UNITS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
